### sv/ert_pkg.sv
// Shared types and constants for the epoch reclaim table.
package ert_pkg;

  // Fixed field widths
  localparam int OP_W    = 3;
  localparam int OWNER_W = 16;
  localparam int SLOT_W  = 6;
  localparam int EPOCH_W = 64;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Command codes
  typedef enum logic [OP_W-1:0] {
    OP_RESERVE   = 3'd0,
    OP_PROTECT   = 3'd1,
    OP_UNPROTECT = 3'd2,
    OP_QUERY     = 3'd3,
    OP_BUMP      = 3'd4
  } op_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_REDUCE,
    ST_PROBE,
    ST_SCAN,
    ST_FIN
  } state_e;

endpackage

### sv/ert_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// A read of the address being written in the same cycle returns the old data.
module ert_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/ert_ctrl.sv
// Command sequencer: decodes a beat, runs the read-modify-write on the two
// slot stores, the reserve probe and the bump scan, and registers the result.
module ert_ctrl #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command side
  input  logic                              start,
  output logic                              busy,
  input  logic [ert_pkg::OP_W-1:0]          op_i,
  input  logic [ert_pkg::OWNER_W-1:0]       requester_id_i,
  input  logic [ert_pkg::SLOT_W-1:0]        start_index_i,
  input  logic [ert_pkg::SLOT_W-1:0]        slot_i,
  input  logic [ert_pkg::EPOCH_W-1:0]       epoch_i,
  // result side
  output logic                              done_o,
  output logic                              status_o,
  output logic [ert_pkg::SLOT_W-1:0]        granted_slot_o,
  output logic                              is_protected_o,
  output logic [ert_pkg::EPOCH_W-1:0]       safe_epoch_o,
  output logic [ert_pkg::EPOCH_W-1:0]       epoch_now_o,
  // shared read address for both stores
  output logic [$clog2(TABLE_ENTRIES)-1:0]  raddr_o,
  // owner store
  output logic                              own_we_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0]  own_waddr_o,
  output logic [ert_pkg::OWNER_W-1:0]       own_wdata_o,
  input  logic [ert_pkg::OWNER_W-1:0]       own_rdata_i,
  // protected-epoch store
  output logic                              ep_we_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0]  ep_waddr_o,
  output logic [ert_pkg::EPOCH_W-1:0]       ep_wdata_o,
  input  logic [ert_pkg::EPOCH_W-1:0]       ep_rdata_i
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  // wide enough for both a slot number and a table index
  localparam int AW    = (IDX_W > ert_pkg::SLOT_W) ? IDX_W : ert_pkg::SLOT_W;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_ENTRIES);
  localparam logic [AW:0]      ENTRIES_X = (AW+1)'(TABLE_ENTRIES);
  localparam logic [AW-1:0]    ENTRIES_A = AW'(TABLE_ENTRIES);

  ert_pkg::state_e state_q, state_d;

  // latched command beat
  ert_pkg::op_e                  op_q;
  logic [ert_pkg::OWNER_W-1:0]   who_q;
  logic [AW-1:0]                 start_q, start_d;
  logic [IDX_W-1:0]              slot_q;
  logic                          slot_ok_q;
  logic [ert_pkg::EPOCH_W-1:0]   epoch_q;

  // probe / scan / clear pointers
  logic [IDX_W-1:0]              iss_idx_q, iss_idx_d, iss_idx_nxt;
  logic [CNT_W-1:0]              iss_cnt_q, iss_cnt_d;
  logic                          chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]              chk_idx_q, chk_idx_d;
  logic [AW-1:0]                 chk_w;
  logic [ert_pkg::EPOCH_W-1:0]   min_q, min_d;

  // architectural epochs and result registers
  logic [ert_pkg::EPOCH_W-1:0]   global_q, global_d;
  logic [ert_pkg::EPOCH_W-1:0]   reclaim_q, reclaim_d;
  logic                          status_q, status_d;
  logic [ert_pkg::SLOT_W-1:0]    granted_q, granted_d;
  logic                          prot_q, prot_d;
  logic                          done_q, done_d;

  // slot decode of the incoming beat
  logic [AW-1:0]                 slot_w;
  logic [IDX_W-1:0]              slot_addr;
  logic                          slot_ok;
  logic                          accept;

  assign slot_w    = AW'(slot_i);
  assign slot_addr = slot_w[IDX_W-1:0];
  assign slot_ok   = {1'b0, slot_w} < ENTRIES_X;
  assign accept    = start && !busy;

  assign iss_idx_nxt = (iss_idx_q == LAST_IDX) ? '0 : iss_idx_q + 1'b1;
  assign chk_w       = AW'(chk_idx_q);

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ert_pkg::ST_CLEAR;
      iss_idx_q <= '0;
      iss_cnt_q <= '0;
      chk_vld_q <= 1'b0;
      global_q  <= ert_pkg::EPOCH_W'(1);
      reclaim_q <= '0;
      status_q  <= ert_pkg::STATUS_OK;
      granted_q <= '0;
      prot_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_idx_q <= iss_idx_d;
      iss_cnt_q <= iss_cnt_d;
      chk_vld_q <= chk_vld_d;
      global_q  <= global_d;
      reclaim_q <= reclaim_d;
      status_q  <= status_d;
      granted_q <= granted_d;
      prot_q    <= prot_d;
      done_q    <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= ert_pkg::op_e'(op_i);
      who_q     <= requester_id_i;
      slot_q    <= slot_addr;
      slot_ok_q <= slot_ok;
      epoch_q   <= epoch_i;
    end
    start_q   <= accept ? AW'(start_index_i) : start_d;
    chk_idx_q <= chk_idx_d;
    min_q     <= min_d;
  end

  // next state, store accesses and result
  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    iss_idx_d   = iss_idx_q;
    iss_cnt_d   = iss_cnt_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = iss_idx_q;
    min_d       = min_q;
    global_d    = global_q;
    reclaim_d   = reclaim_q;
    status_d    = status_q;
    granted_d   = granted_q;
    prot_d      = prot_q;
    done_d      = 1'b0;
    busy        = 1'b1;
    raddr_o     = iss_idx_q;
    own_we_o    = 1'b0;
    own_waddr_o = chk_idx_q;
    own_wdata_o = who_q;
    ep_we_o     = 1'b0;
    ep_waddr_o  = slot_q;
    ep_wdata_o  = epoch_q;

    unique case (state_q)
      // zero both stores, one entry per cycle
      ert_pkg::ST_CLEAR: begin
        own_we_o    = 1'b1;
        own_waddr_o = iss_idx_q;
        own_wdata_o = '0;
        ep_we_o     = 1'b1;
        ep_waddr_o  = iss_idx_q;
        ep_wdata_o  = '0;
        iss_idx_d   = iss_idx_nxt;
        if (iss_idx_q == LAST_IDX) begin
          state_d = ert_pkg::ST_IDLE;
        end
      end

      // read the addressed slot while the beat is taken
      ert_pkg::ST_IDLE: begin
        busy    = 1'b0;
        raddr_o = slot_addr;
        if (accept) begin
          state_d = ert_pkg::ST_EXEC;
        end
      end

      // single-slot and unknown commands finish here; reserve and bump branch off
      ert_pkg::ST_EXEC: begin
        status_d  = ert_pkg::STATUS_OK;
        granted_d = '0;
        prot_d    = 1'b0;
        unique case (op_q)
          ert_pkg::OP_PROTECT: begin
            ep_we_o = slot_ok_q;
            done_d  = 1'b1;
            state_d = ert_pkg::ST_IDLE;
          end
          ert_pkg::OP_UNPROTECT: begin
            ep_we_o    = slot_ok_q;
            ep_wdata_o = '0;
            done_d     = 1'b1;
            state_d    = ert_pkg::ST_IDLE;
          end
          ert_pkg::OP_QUERY: begin
            prot_d  = slot_ok_q && (ep_rdata_i != '0);
            done_d  = 1'b1;
            state_d = ert_pkg::ST_IDLE;
          end
          ert_pkg::OP_RESERVE: begin
            state_d = ert_pkg::ST_REDUCE;
          end
          ert_pkg::OP_BUMP: begin
            iss_idx_d = '0;
            iss_cnt_d = '0;
            min_d     = global_q;
            state_d   = ert_pkg::ST_SCAN;
          end
          default: begin
            done_d  = 1'b1;
            state_d = ert_pkg::ST_IDLE;
          end
        endcase
      end

      // bring the probe start into the table range
      ert_pkg::ST_REDUCE: begin
        if ({1'b0, start_q} >= ENTRIES_X) begin
          start_d = start_q - ENTRIES_A;
        end else begin
          iss_idx_d = start_q[IDX_W-1:0];
          iss_cnt_d = '0;
          state_d   = ert_pkg::ST_PROBE;
        end
      end

      // pipelined linear probe: issue one read, check the previous one
      ert_pkg::ST_PROBE: begin
        if (iss_cnt_q != FULL_CNT) begin
          chk_vld_d = 1'b1;
          iss_cnt_d = iss_cnt_q + 1'b1;
          iss_idx_d = iss_idx_nxt;
        end
        if (chk_vld_q) begin
          if (own_rdata_i == '0) begin
            own_we_o  = 1'b1;
            granted_d = chk_w[ert_pkg::SLOT_W-1:0];
            done_d    = 1'b1;
            state_d   = ert_pkg::ST_IDLE;
          end else if (iss_cnt_q == FULL_CNT) begin
            status_d = ert_pkg::STATUS_FULL;
            done_d   = 1'b1;
            state_d  = ert_pkg::ST_IDLE;
          end
        end
      end

      // pipelined minimum over nonzero protected epochs
      ert_pkg::ST_SCAN: begin
        if (iss_cnt_q != FULL_CNT) begin
          chk_vld_d = 1'b1;
          iss_cnt_d = iss_cnt_q + 1'b1;
          iss_idx_d = iss_idx_nxt;
        end
        if (chk_vld_q && (ep_rdata_i != '0) && (ep_rdata_i < min_q)) begin
          min_d = ep_rdata_i;
        end
        if (chk_vld_q && (iss_cnt_q == FULL_CNT)) begin
          state_d = ert_pkg::ST_FIN;
        end
      end

      // commit the bump; min_q is never zero
      ert_pkg::ST_FIN: begin
        reclaim_d = min_q - 1'b1;
        global_d  = (global_q == '1) ? global_q : global_q + 1'b1;
        done_d    = 1'b1;
        state_d   = ert_pkg::ST_IDLE;
      end

      default: begin
        state_d = ert_pkg::ST_IDLE;
      end
    endcase
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign granted_slot_o = granted_q;
  assign is_protected_o = prot_q;
  assign safe_epoch_o   = reclaim_q;
  assign epoch_now_o    = global_q;

endmodule

### sv/epoch_reclaim_table_unit.sv
// Channel   Handshake            Beat fields
// command   start in, busy out   op_i, requester_id_i, start_index_i, slot_i, epoch_i
// result    done_o strobe        status_o, granted_slot_o, is_protected_o,
//                                safe_epoch_o, epoch_now_o
//
// A beat is taken when start is high and busy is low; its result shows on done_o
// for one cycle. Protect, unprotect, query and unknown ops finish after the registered
// read of the slot store. Reserve first brings the start index into the table range,
// then probes slots linearly from it; bump scans every entry, one store read per
// cycle. After reset busy stays high while both stores are zeroed; results cannot
// stall.
module epoch_reclaim_table_unit #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [ert_pkg::OP_W-1:0]     op_i,
  input  logic [ert_pkg::OWNER_W-1:0]  requester_id_i,
  input  logic [ert_pkg::SLOT_W-1:0]   start_index_i,
  input  logic [ert_pkg::SLOT_W-1:0]   slot_i,
  input  logic [ert_pkg::EPOCH_W-1:0]  epoch_i,
  output logic                         done_o,
  output logic                         status_o,
  output logic [ert_pkg::SLOT_W-1:0]   granted_slot_o,
  output logic                         is_protected_o,
  output logic [ert_pkg::EPOCH_W-1:0]  safe_epoch_o,
  output logic [ert_pkg::EPOCH_W-1:0]  epoch_now_o
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  logic [IDX_W-1:0]             raddr;
  logic                         own_we;
  logic [IDX_W-1:0]             own_waddr;
  logic [ert_pkg::OWNER_W-1:0]  own_wdata;
  logic [ert_pkg::OWNER_W-1:0]  own_rdata;
  logic                         ep_we;
  logic [IDX_W-1:0]             ep_waddr;
  logic [ert_pkg::EPOCH_W-1:0]  ep_wdata;
  logic [ert_pkg::EPOCH_W-1:0]  ep_rdata;

  // sequencer
  ert_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .requester_id_i(requester_id_i),
    .start_index_i (start_index_i),
    .slot_i        (slot_i),
    .epoch_i       (epoch_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .granted_slot_o(granted_slot_o),
    .is_protected_o(is_protected_o),
    .safe_epoch_o  (safe_epoch_o),
    .epoch_now_o   (epoch_now_o),
    .raddr_o       (raddr),
    .own_we_o      (own_we),
    .own_waddr_o   (own_waddr),
    .own_wdata_o   (own_wdata),
    .own_rdata_i   (own_rdata),
    .ep_we_o       (ep_we),
    .ep_waddr_o    (ep_waddr),
    .ep_wdata_o    (ep_wdata),
    .ep_rdata_i    (ep_rdata)
  );

  // slot owner store
  ert_ram #(
    .WIDTH(ert_pkg::OWNER_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_owner_ram (
    .clk_i  (clk_i),
    .we_i   (own_we),
    .waddr_i(own_waddr),
    .wdata_i(own_wdata),
    .raddr_i(raddr),
    .rdata_o(own_rdata)
  );

  // protected epoch store
  ert_ram #(
    .WIDTH(ert_pkg::EPOCH_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_epoch_ram (
    .clk_i  (clk_i),
    .we_i   (ep_we),
    .waddr_i(ep_waddr),
    .wdata_i(ep_wdata),
    .raddr_i(raddr),
    .rdata_o(ep_rdata)
  );

endmodule
